// ----- src/fra_pkg.sv -----
package fra_pkg;

  localparam int MAX_FRAGMENTS = 128;
  localparam int MAP_W         = 128;
  localparam int CAP_W         = 18;
  localparam int SUM_OUT_W     = 20;

  localparam logic [CAP_W-1:0]     CAP_RESET  = 18'd131072;
  localparam logic [15:0]          LAST_RESET = 16'hFFFF;
  localparam logic [15:0]          CNT_MAX    = 16'hFFFF;
  localparam logic [SUM_OUT_W-1:0] SUM_MAX    = 20'hFFFFF;

  typedef struct packed {
    logic [15:0] frame_number;
    logic [6:0]  fragment_index;
    logic [7:0]  fragments_per_frame;
    logic        flush_flag;
    logic [10:0] payload_bytes;
  } frag_t;

  typedef struct packed {
    logic [16:0] write_offset;
    logic        write_enable;
    logic [17:0] frame_bytes;
    logic        frame_done;
    logic [15:0] missed_frames;
    logic        flush_out;
    logic [15:0] ack_frame;
    logic [63:0] ack_bits_low;
    logic [63:0] ack_bits_high;
    logic [19:0] useful_sum;
    logic [19:0] total_sum;
  } res_t;

  typedef struct packed {
    logic        adv;
    logic        en;
    logic [15:0] useful;
    logic [15:0] total;
  } win_upd_t;

endpackage

// ----- src/fra_window.sv -----
module fra_window #(
  parameter int WINDOW_FRAMES = 15,
  parameter int SUM_W         = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fra_pkg::win_upd_t  req,
  output logic [SUM_W-1:0]   sum_u,
  output logic [SUM_W-1:0]   sum_t
);
  import fra_pkg::*;

  generate
    if (WINDOW_FRAMES > 1) begin : g_line
      localparam int D = WINDOW_FRAMES - 1;

      logic [15:0]      u_line_r [D];
      logic [15:0]      t_line_r [D];
      logic [SUM_W-1:0] u_sum_r, t_sum_r;
      logic [SUM_W-1:0] u_sum_nxt, t_sum_nxt;

      // leaving frame joins the line, oldest frame drops out
      assign u_sum_nxt = req.adv ?
        (u_sum_r + SUM_W'(req.useful) - SUM_W'(u_line_r[D-1])) : u_sum_r;
      assign t_sum_nxt = req.adv ?
        (t_sum_r + SUM_W'(req.total) - SUM_W'(t_line_r[D-1])) : t_sum_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          u_sum_r <= '0;
          t_sum_r <= '0;
          for (int i = 0; i < D; i++) begin
            u_line_r[i] <= '0;
            t_line_r[i] <= '0;
          end
        end else if (req.en && req.adv) begin
          u_sum_r     <= u_sum_nxt;
          t_sum_r     <= t_sum_nxt;
          u_line_r[0] <= req.useful;
          t_line_r[0] <= req.total;
          for (int i = 1; i < D; i++) begin
            u_line_r[i] <= u_line_r[i-1];
            t_line_r[i] <= t_line_r[i-1];
          end
        end
      end

      assign sum_u = u_sum_nxt;
      assign sum_t = t_sum_nxt;
    end else begin : g_none
      assign sum_u = '0;
      assign sum_t = '0;
    end
  endgenerate

endmodule

// ----- src/fra_core.sv -----
module fra_core #(
  parameter int FRAGMENT_BYTES = 1024,
  parameter int WINDOW_FRAMES  = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  fra_pkg::frag_t    item,
  input  logic [17:0]       cap,
  output fra_pkg::res_t     res
);
  import fra_pkg::*;

  localparam int SUM_W  = 16 + ((WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 0);
  localparam int EXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int OFF_W  = $clog2(FRAGMENT_BYTES) + 8;
  localparam int END_W  = (OFF_W + 1 > CAP_W + 1) ? OFF_W + 1 : CAP_W + 1;

  logic [15:0]      frame_r, last_r;
  logic [MAP_W-1:0] map_r;
  logic [17:0]      size_r;
  logic             skip_r;
  logic [15:0]      useful_r, total_r;

  logic             new_frame;
  logic [MAP_W-1:0] base_map, map_nxt, need_mask;
  logic [17:0]      base_size, size_nxt;
  logic             base_skip, skip_nxt;
  logic [15:0]      base_useful, base_total, useful_nxt, total_nxt, last_nxt;
  logic             in_range, was_set, all_here, done;
  logic [7:0]       nclip;
  logic [END_W-1:0] offset, end_ofs;
  logic [SUM_W-1:0] sum_u, sum_t;
  logic [EXT_W-1:0] u_ext, t_ext;
  win_upd_t         wreq;

  assign new_frame   = item.frame_number != frame_r;
  assign base_map    = new_frame ? '0 : map_r;
  assign base_size   = new_frame ? '0 : size_r;
  assign base_skip   = new_frame ? 1'b0 : skip_r;
  assign base_useful = new_frame ? '0 : useful_r;
  assign base_total  = new_frame ? '0 : total_r;

  assign wreq.adv    = new_frame;
  assign wreq.en     = upd;
  assign wreq.useful = useful_r;
  assign wreq.total  = total_r;

  fra_window #(
    .WINDOW_FRAMES(WINDOW_FRAMES),
    .SUM_W(SUM_W)
  ) u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (wreq),
    .sum_u(sum_u),
    .sum_t(sum_t)
  );

  assign in_range = {1'b0, item.fragment_index} < 8'(MAX_FRAGMENTS);
  assign was_set  = in_range ? base_map[item.fragment_index] : 1'b1;
  assign nclip    = (item.fragments_per_frame > 8'(MAX_FRAGMENTS)) ?
                    8'(MAX_FRAGMENTS) : item.fragments_per_frame;

  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      map_nxt[i]   = base_map[i] | (in_range && (item.fragment_index == 7'(i)));
      need_mask[i] = 8'(i) < nclip;
    end
  end

  assign all_here   = (map_nxt & need_mask) == need_mask;
  assign total_nxt  = (base_total == CNT_MAX) ? base_total : base_total + 16'd1;
  assign useful_nxt = (was_set || base_useful == CNT_MAX) ? base_useful
                                                          : base_useful + 16'd1;

  assign offset   = END_W'(FRAGMENT_BYTES) * END_W'(item.fragment_index);
  assign end_ofs  = offset + END_W'(item.payload_bytes);
  assign skip_nxt = base_skip || (end_ofs > END_W'(cap));
  assign size_nxt = (!skip_nxt && end_ofs > END_W'(base_size)) ? end_ofs[17:0] : base_size;
  assign done     = !skip_nxt && all_here && (item.frame_number != last_r);
  assign last_nxt = done ? item.frame_number : last_r;

  assign u_ext = EXT_W'(sum_u) + EXT_W'(useful_nxt);
  assign t_ext = EXT_W'(sum_t) + EXT_W'(total_nxt);

  always_comb begin
    res.write_offset  = offset[16:0];
    res.write_enable  = !skip_nxt && !was_set;
    res.frame_bytes   = size_nxt;
    res.frame_done    = done;
    res.missed_frames = done ? (item.frame_number - last_r - 16'd1) : '0;
    res.flush_out     = done && item.flush_flag;
    res.ack_frame     = item.frame_number;
    res.ack_bits_low  = map_nxt[63:0];
    res.ack_bits_high = map_nxt[127:64];
    res.useful_sum    = (u_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : u_ext[SUM_OUT_W-1:0];
    res.total_sum     = (t_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : t_ext[SUM_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      last_r   <= LAST_RESET;
      map_r    <= '0;
      size_r   <= '0;
      skip_r   <= 1'b0;
      useful_r <= '0;
      total_r  <= '0;
    end else if (upd) begin
      frame_r  <= item.frame_number;
      last_r   <= last_nxt;
      map_r    <= map_nxt;
      size_r   <= size_nxt;
      skip_r   <= skip_nxt;
      useful_r <= useful_nxt;
      total_r  <= total_nxt;
    end
  end

  a_last_tracks_done: assert property (@(posedge clk) disable iff (!rst_n)
    upd && res.frame_done |=> last_r == frame_r)
    else $error("completed frame not recorded");

  a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !new_frame && skip_r |-> !res.write_enable && !res.frame_done)
    else $error("skipped frame stored or completed");

  a_useful_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    useful_r <= total_r)
    else $error("useful count above total count");

endmodule

// ----- src/fragment_reassembly_ack_tracker_top.sv -----
// path: input transaction passes the input register, then the result register, before result valid
// throughput: one fragment header per cycle unless out_stall holds a waiting result
// output register holds a stalled result: while it waits, only an empty input register takes new input
// reset: synchronous active-low rst_n clears frame state, bitmap and window counters
// reset: buffer capacity returns to 131072, no clearing pass is needed
module fragment_reassembly_ack_tracker_top #(
  parameter int FRAGMENT_BYTES = 1024,
  parameter int WINDOW_FRAMES  = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_frame_number,
  input  logic [6:0]  in_fragment_index,
  input  logic [7:0]  in_fragments_per_frame,
  input  logic        in_flush_flag,
  input  logic [10:0] in_payload_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_write_offset,
  output logic        out_write_enable,
  output logic [17:0] out_frame_bytes,
  output logic        out_frame_done,
  output logic [15:0] out_missed_frames,
  output logic        out_flush_out,
  output logic [15:0] out_ack_frame,
  output logic [63:0] out_ack_bits_low,
  output logic [63:0] out_ack_bits_high,
  output logic [19:0] out_useful_sum,
  output logic [19:0] out_total_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data
);
  import fra_pkg::*;

  logic        s0_valid_r;
  frag_t       s0_item_r;
  logic        out_valid_r;
  res_t        out_res_r;
  res_t        res;
  logic [17:0] cap_r;
  logic        out_adv, upd;

  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = s0_valid_r && !out_adv;
  assign upd       = s0_valid_r && out_adv;
  assign cfg_ready = 1'b1;

  fra_core #(
    .FRAGMENT_BYTES(FRAGMENT_BYTES),
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (upd),
    .item (s0_item_r),
    .cap  (cap_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (!in_stall) begin
        s0_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s0_valid_r;
      end
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_item_r.frame_number        <= in_frame_number;
      s0_item_r.fragment_index      <= in_fragment_index;
      s0_item_r.fragments_per_frame <= in_fragments_per_frame;
      s0_item_r.flush_flag          <= in_flush_flag;
      s0_item_r.payload_bytes       <= in_payload_bytes;
    end
    if (upd) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_offset  = out_res_r.write_offset;
  assign out_write_enable  = out_res_r.write_enable;
  assign out_frame_bytes   = out_res_r.frame_bytes;
  assign out_frame_done    = out_res_r.frame_done;
  assign out_missed_frames = out_res_r.missed_frames;
  assign out_flush_out     = out_res_r.flush_out;
  assign out_ack_frame     = out_res_r.ack_frame;
  assign out_ack_bits_low  = out_res_r.ack_bits_low;
  assign out_ack_bits_high = out_res_r.ack_bits_high;
  assign out_useful_sum    = out_res_r.useful_sum;
  assign out_total_sum     = out_res_r.total_sum;

endmodule

// ----- bench/fragment_reassembly_ack_tracker_top_test.sv -----
`timescale 1ns / 100ps

module fragment_reassembly_ack_tracker_top_test;
  import fra_pkg::*;

  localparam int FRAG_BYTES = 1024;
  localparam int WINDOW = 15;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_frame_number = '0;
  logic [6:0] in_fragment_index = '0;
  logic [7:0] in_fragments_per_frame = '0;
  logic in_flush_flag = 1'b0;
  logic [10:0] in_payload_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_write_offset;
  logic out_write_enable;
  logic [17:0] out_frame_bytes;
  logic out_frame_done;
  logic [15:0] out_missed_frames;
  logic out_flush_out;
  logic [15:0] out_ack_frame;
  logic [63:0] out_ack_bits_low;
  logic [63:0] out_ack_bits_high;
  logic [19:0] out_useful_sum;
  logic [19:0] out_total_sum;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [17:0] cfg_data = '0;

  fragment_reassembly_ack_tracker_top #(
    .FRAGMENT_BYTES(FRAG_BYTES),
    .WINDOW_FRAMES(WINDOW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_frame_number(in_frame_number),
    .in_fragment_index(in_fragment_index),
    .in_fragments_per_frame(in_fragments_per_frame),
    .in_flush_flag(in_flush_flag),
    .in_payload_bytes(in_payload_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_offset(out_write_offset),
    .out_write_enable(out_write_enable),
    .out_frame_bytes(out_frame_bytes),
    .out_frame_done(out_frame_done),
    .out_missed_frames(out_missed_frames),
    .out_flush_out(out_flush_out),
    .out_ack_frame(out_ack_frame),
    .out_ack_bits_low(out_ack_bits_low),
    .out_ack_bits_high(out_ack_bits_high),
    .out_useful_sum(out_useful_sum),
    .out_total_sum(out_total_sum),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // tracker state mirrored by the predictor
  logic [17:0] trk_capacity = CAP_RESET;
  logic [15:0] trk_frame = '0;
  logic [127:0] trk_map = '0;
  logic [17:0] trk_size = '0;
  logic trk_skip = 1'b0;
  logic [15:0] trk_last_done = LAST_RESET;
  int trk_slot = 0;
  logic [15:0] trk_useful [WINDOW];
  logic [15:0] trk_total [WINDOW];

  res_t pending_results [$];
  int mismatches = 0;
  int cycle_count = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  logic [15:0] stim_frame = '0;

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      trk_useful[i] = '0;
      trk_total[i] = '0;
    end
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic res_t track_fragment(input logic [15:0] fnum, input logic [6:0] idx,
                                          input logic [7:0] nfrag, input logic flush,
                                          input logic [10:0] payload);
    res_t r;
    logic [127:0] bitv;
    logic [127:0] need;
    logic was_set;
    int offset_i;
    int end_i;
    int n;
    int su;
    int st;
    r = '0;
    was_set = 1'b1;
    su = 0;
    st = 0;
    if (fnum != trk_frame) begin
      trk_slot = (trk_slot + 1) % WINDOW;
      trk_useful[trk_slot] = '0;
      trk_total[trk_slot] = '0;
      trk_skip = 1'b0;
      trk_size = '0;
      trk_frame = fnum;
      trk_map = '0;
    end
    if (int'(idx) < MAX_FRAGMENTS) begin
      bitv = 128'd1 << idx;
      was_set = (trk_map & bitv) != '0;
      trk_map = trk_map | bitv;
    end
    if (trk_total[trk_slot] != CNT_MAX) trk_total[trk_slot] = trk_total[trk_slot] + 16'd1;
    if (!was_set && trk_useful[trk_slot] != CNT_MAX)
      trk_useful[trk_slot] = trk_useful[trk_slot] + 16'd1;
    offset_i = FRAG_BYTES * int'(idx);
    end_i = offset_i + int'(payload);
    if (!trk_skip && end_i > int'(trk_capacity)) trk_skip = 1'b1;
    if (!trk_skip) begin
      r.write_enable = !was_set;
      if (end_i > int'(trk_size)) trk_size = end_i[17:0];
      n = (int'(nfrag) > MAX_FRAGMENTS) ? MAX_FRAGMENTS : int'(nfrag);
      need = (n >= 128) ? {128{1'b1}} : ((128'd1 << n) - 128'd1);
      if ((trk_map & need) == need && fnum != trk_last_done) begin
        r.frame_done = 1'b1;
        r.flush_out = flush;
        r.missed_frames = fnum - trk_last_done - 16'd1;
        trk_last_done = fnum;
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      su += int'(trk_useful[i]);
      st += int'(trk_total[i]);
    end
    if (su > int'(SUM_MAX)) su = int'(SUM_MAX);
    if (st > int'(SUM_MAX)) st = int'(SUM_MAX);
    r.write_offset = offset_i[16:0];
    r.frame_bytes = trk_size;
    r.ack_frame = trk_frame;
    r.ack_bits_low = trk_map[63:0];
    r.ack_bits_high = trk_map[127:64];
    r.useful_sum = su[19:0];
    r.total_sum = st[19:0];
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_write_offset, out_write_enable, out_frame_bytes, out_frame_done,
             out_missed_frames, out_flush_out, out_ack_frame, out_ack_bits_low,
             out_ack_bits_high, out_useful_sum, out_total_sum};
      if (pending_results.size() == 0) begin
        log_mismatch("result transaction with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("write_offset", got.write_offset, want.write_offset);
        check_field("write_enable", got.write_enable, want.write_enable);
        check_field("frame_bytes", got.frame_bytes, want.frame_bytes);
        check_field("frame_done", got.frame_done, want.frame_done);
        check_field("missed_frames", got.missed_frames, want.missed_frames);
        check_field("flush_out", got.flush_out, want.flush_out);
        check_field("ack_frame", got.ack_frame, want.ack_frame);
        check_field("ack_bits_low", got.ack_bits_low, want.ack_bits_low);
        check_field("ack_bits_high", got.ack_bits_high, want.ack_bits_high);
        check_field("useful_sum", got.useful_sum, want.useful_sum);
        check_field("total_sum", got.total_sum, want.total_sum);
      end
    end
  end

  task automatic send_fragment(input logic [15:0] fnum, input logic [6:0] idx,
                               input logic [7:0] nfrag, input logic flush,
                               input logic [10:0] payload);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_number <= fnum;
    in_fragment_index <= idx;
    in_fragments_per_frame <= nfrag;
    in_flush_flag <= flush;
    in_payload_bytes <= payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(track_fragment(fnum, idx, nfrag, flush, payload));
    stim_frame = fnum;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [17:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    trk_capacity = value;
  endtask

  task automatic test_directed();
    send_fragment(16'd0, 7'd0, 8'd1, 1'b1, 11'd0);
    send_fragment(16'd0, 7'd0, 8'd1, 1'b0, 11'd0);
    send_fragment(16'd1, 7'd127, 8'd128, 1'b0, 11'd1024);
    send_fragment(16'd1, 7'd64, 8'd255, 1'b1, 11'd1023);
    send_fragment(16'd1, 7'd127, 8'd128, 1'b0, 11'd1024);
    // zero fragment count completes at once
    send_fragment(16'd2, 7'd5, 8'd0, 1'b1, 11'd1000);
    send_fragment(16'd65535, 7'd0, 8'd1, 1'b0, 11'd512);
    send_fragment(16'd65535, 7'd1, 8'd2, 1'b1, 11'd1024);
    // frame number wraps past the last completed one
    send_fragment(16'd0, 7'd0, 8'd1, 1'b1, 11'd1);
    send_fragment(16'd7, 7'd1, 8'd2, 1'b0, 11'd1024);
    send_fragment(16'd7, 7'd0, 8'd2, 1'b1, 11'd1024);
    send_fragment(16'h5555, 7'd85, 8'd86, 1'b0, 11'd1023);
    send_fragment(16'haaaa, 7'd42, 8'd43, 1'b1, 11'd682);
    send_fragment(16'haaaa, 7'd63, 8'd128, 1'b0, 11'd1023);
    send_fragment(16'haaaa, 7'd42, 8'd200, 1'b1, 11'd341);
    send_fragment(16'haaab, 7'd0, 8'd129, 1'b0, 11'd1024);
  endtask

  task automatic test_capacity_limits();
    write_capacity(18'd0);
    send_fragment(16'd200, 7'd0, 8'd1, 1'b0, 11'd0);
    // overflow skips the rest of the frame
    send_fragment(16'd201, 7'd0, 8'd1, 1'b1, 11'd1);
    send_fragment(16'd201, 7'd0, 8'd1, 1'b1, 11'd0);
    send_fragment(16'd202, 7'd1, 8'd2, 1'b0, 11'd0);
    write_capacity(18'd5000);
    send_fragment(16'd300, 7'd0, 8'd3, 1'b0, 11'd1024);
    send_fragment(16'd300, 7'd1, 8'd3, 1'b0, 11'd1024);
    send_fragment(16'd300, 7'd4, 8'd3, 1'b0, 11'd1024);
    send_fragment(16'd300, 7'd2, 8'd3, 1'b0, 11'd1024);
    send_fragment(16'd301, 7'd4, 8'd5, 1'b1, 11'd904);
    send_fragment(16'd301, 7'd3, 8'd5, 1'b1, 11'd1024);
    write_capacity(18'($urandom_range(131072)));
    for (int k = 0; k < 6; k++)
      send_fragment(16'd302, 7'($urandom_range(127)), 8'd3, 1'b0, 11'($urandom_range(1024)));
    write_capacity(CAP_RESET);
    send_fragment(16'd303, 7'd127, 8'd1, 1'b0, 11'd1024);
  endtask

  task automatic test_random_frames(input int item_goal);
    int sent;
    int count;
    int j;
    int tmp;
    int choice;
    int order [128];
    logic [15:0] fnum;
    logic [7:0] nfrag;
    logic flush;
    logic [10:0] payload;
    sent = 0;
    while (sent < item_goal) begin
      choice = $urandom_range(99);
      if (choice < 8) begin
        fnum = ($urandom_range(1) == 1) ? stim_frame : 16'($urandom);
        send_fragment(fnum, 7'($urandom), 8'($urandom), 1'($urandom),
                      11'($urandom_range(1024)));
        sent++;
        continue;
      end
      if (choice < 11) drain_results();
      choice = $urandom_range(99);
      if (choice < 70) fnum = stim_frame + 16'd1;
      else if (choice < 80) fnum = stim_frame + 16'($urandom_range(3000, 2));
      else if (choice < 88) fnum = stim_frame;
      else fnum = 16'($urandom);
      choice = $urandom_range(99);
      if (choice < 80) nfrag = 8'($urandom_range(8, 1));
      else if (choice < 95) nfrag = 8'($urandom_range(128, 9));
      else if (choice < 97) nfrag = 8'd0;
      else nfrag = 8'($urandom_range(255, 129));
      if (nfrag == 8'd0) count = $urandom_range(4, 1);
      else count = (int'(nfrag) > MAX_FRAGMENTS) ? MAX_FRAGMENTS : int'(nfrag);
      for (int k = 0; k < count; k++) order[k] = k;
      for (int k = count - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      flush = 1'($urandom);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(99) < 8) continue;
        if (order[k] == count - 1 || $urandom_range(99) < 10)
          payload = 11'($urandom_range(1024));
        else
          payload = 11'd1024;
        send_fragment(fnum, 7'(order[k]), nfrag, flush, payload);
        sent++;
        if ($urandom_range(99) < 10) begin
          send_fragment(fnum, 7'(order[k]), nfrag, flush, payload);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_gap_pct = 10;
    receiver_stall_pct = 53;
    test_directed();
    test_random_frames(350);

    sender_gap_pct = 53;
    receiver_stall_pct = 10;
    test_capacity_limits();
    write_capacity(18'd6144);
    test_random_frames(350);

    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    write_capacity(CAP_RESET);
    test_random_frames(300);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/fra_pkg.sv
src/fra_window.sv
src/fra_core.sv
src/fragment_reassembly_ack_tracker_top.sv
bench/fragment_reassembly_ack_tracker_top_test.sv
